### sv/dssm_pkg.sv
package dssm_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int WORD_W        = 32;
  localparam int OP_W          = 2;
  localparam int STATUS_W      = 2;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic exec;
  } cmd_t;

endpackage

### sv/dssm_req_if.sv
interface dssm_req_if;
  import dssm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic                     stack_sel;
  logic signed [WORD_W-1:0] push_value;

  modport source (output valid, output opcode, output stack_sel, output push_value,
                  input ready);
  modport sink (input valid, input opcode, input stack_sel, input push_value,
                output ready);

endinterface

### sv/dssm_rsp_if.sv
interface dssm_rsp_if;
  import dssm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] top_value;
  logic [STATUS_W-1:0]      status;
  logic                     lower_empty;
  logic                     upper_empty;
  logic                     all_full;

  modport source (output valid, output top_value, output status, output lower_empty,
                  output upper_empty, output all_full, input ready);
  modport sink (input valid, input top_value, input status, input lower_empty,
                input upper_empty, input all_full, output ready);

endinterface

### sv/dssm_ctrl.sv
module dssm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output dssm_pkg::cmd_t cmd
);
  import dssm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd.exec  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.exec = in_valid;
      end
      S_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### sv/dssm_dp.sv
module dssm_dp #(
  parameter int DEPTH = dssm_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dssm_pkg::cmd_t                     cmd,
  input  logic [dssm_pkg::OP_W-1:0]          opcode,
  input  logic                               stack_sel,
  input  logic signed [dssm_pkg::WORD_W-1:0] push_value,
  output logic signed [dssm_pkg::WORD_W-1:0] top_value,
  output logic [dssm_pkg::STATUS_W-1:0]      status,
  output logic                               lower_empty,
  output logic                               upper_empty,
  output logic                               all_full
);
  import dssm_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];

  logic [CW-1:0]       lower_cnt_r, lower_cnt_nxt;
  logic [CW-1:0]       upper_cnt_r, upper_cnt_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                top_sel_r;
  logic [WORD_W-1:0]   rd_data_r;

  logic [CW-1:0] sel_cnt;
  logic [CW:0]   used;
  logic          full;
  logic          we;
  logic          re;
  logic [CW-1:0] waddr;
  logic [CW-1:0] raddr;

  always_comb begin
    sel_cnt       = stack_sel ? upper_cnt_r : lower_cnt_r;
    used          = {1'b0, lower_cnt_r} + {1'b0, upper_cnt_r};
    full          = (used >= DEPTH_S);
    lower_cnt_nxt = lower_cnt_r;
    upper_cnt_nxt = upper_cnt_r;
    status_nxt    = ST_OK;
    we            = 1'b0;
    re            = 1'b0;
    waddr         = stack_sel ? (DEPTH_C - CW'(1) - upper_cnt_r) : lower_cnt_r;
    raddr         = stack_sel ? (DEPTH_C - upper_cnt_r) : (lower_cnt_r - CW'(1));
    priority if (opcode == OP_PUSH) begin
      if (full) begin
        status_nxt = ST_OVERFLOW;
      end else begin
        we = 1'b1;
        if (stack_sel) begin
          upper_cnt_nxt = upper_cnt_r + CW'(1);
        end else begin
          lower_cnt_nxt = lower_cnt_r + CW'(1);
        end
      end
    end else if (opcode == OP_POP) begin
      if (sel_cnt == '0) begin
        status_nxt = ST_UNDERFLOW;
      end else if (stack_sel) begin
        upper_cnt_nxt = upper_cnt_r - CW'(1);
      end else begin
        lower_cnt_nxt = lower_cnt_r - CW'(1);
      end
    end else if (opcode == OP_READ) begin
      if (sel_cnt == '0) begin
        status_nxt = ST_UNDERFLOW;
      end else begin
        re = 1'b1;
      end
    end else begin
      status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_cnt_r <= '0;
      upper_cnt_r <= '0;
    end else if (cmd.exec) begin
      lower_cnt_r <= lower_cnt_nxt;
      upper_cnt_r <= upper_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r  <= status_nxt;
      top_sel_r <= re;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && we) begin
      mem[waddr[AW-1:0]] <= push_value;
    end
    if (cmd.exec && re) begin
      rd_data_r <= mem[raddr[AW-1:0]];
    end
  end

  assign top_value   = top_sel_r ? rd_data_r : '0;
  assign status      = status_r;
  assign lower_empty = (lower_cnt_r == '0);
  assign upper_empty = (upper_cnt_r == '0);
  assign all_full    = full;

endmodule

### sv/dual_stack_shared_memory.sv
// Channel   Dir   Fields                                               Handshake
// in_req    in    opcode, stack_sel, push_value                        valid/ready
// out_rsp   out   top_value, status, lower_empty, upper_empty, all_full valid/ready
//
// A request is taken when the block is idle; its result is valid in the next cycle.
// The result is held until it is taken, and the next request is taken after that,
// so the block does not take a new request while a result is still waiting.
// The state machine takes a request only in its idle state.
// Reset clears both stack counts; the word memory is not cleared.
module dual_stack_shared_memory #(
  parameter int DEPTH = dssm_pkg::DEPTH_DEFAULT
) (
  input logic        clk,
  input logic        rst_n,
  dssm_req_if.sink   in_req,
  dssm_rsp_if.source out_rsp
);
  import dssm_pkg::*;

  cmd_t cmd;

  dssm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd)
  );

  dssm_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .opcode      (in_req.opcode),
    .stack_sel   (in_req.stack_sel),
    .push_value  (in_req.push_value),
    .top_value   (out_rsp.top_value),
    .status      (out_rsp.status),
    .lower_empty (out_rsp.lower_empty),
    .upper_empty (out_rsp.upper_empty),
    .all_full    (out_rsp.all_full)
  );

endmodule

### sim/dssm_checker.sv
`timescale 1ns / 100ps

module dssm_checker #(
  parameter int DEPTH = dssm_pkg::DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst_n,
  dssm_req_if  req,
  dssm_rsp_if  rsp,
  output int   fail_count,
  output int   outstanding
);
  import dssm_pkg::*;

  typedef struct {
    logic signed [WORD_W-1:0] top_value;
    logic [STATUS_W-1:0]      status;
    logic                     lower_empty;
    logic                     upper_empty;
    logic                     all_full;
  } stack_rsp_t;

  logic [WORD_W-1:0] words [DEPTH];
  int unsigned       lower_cnt = 0;
  int unsigned       upper_cnt = 0;
  stack_rsp_t        rsp_due [$];
  int                fails = 0;

  function automatic stack_rsp_t stack_apply(logic [OP_W-1:0] op, logic sel,
                                             logic [WORD_W-1:0] val);
    stack_rsp_t r;
    r.top_value = '0;
    r.status    = ST_OK;
    case (op)
      OP_PUSH: begin
        if (lower_cnt + upper_cnt >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else if (sel) begin
          words[DEPTH - 1 - upper_cnt] = val;
          upper_cnt++;
        end else begin
          words[lower_cnt] = val;
          lower_cnt++;
        end
      end
      OP_POP: begin
        if ((sel ? upper_cnt : lower_cnt) == 0) begin
          r.status = ST_UNDERFLOW;
        end else if (sel) begin
          upper_cnt--;
        end else begin
          lower_cnt--;
        end
      end
      OP_READ: begin
        if ((sel ? upper_cnt : lower_cnt) == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          r.top_value = sel ? words[DEPTH - upper_cnt] : words[lower_cnt - 1];
        end
      end
      default: begin
      end
    endcase
    r.lower_empty = (lower_cnt == 0);
    r.upper_empty = (upper_cnt == 0);
    r.all_full    = (lower_cnt + upper_cnt >= DEPTH);
    return r;
  endfunction

  task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : monitor
    stack_rsp_t want;
    if (!rst_n) begin
      lower_cnt = 0;
      upper_cnt = 0;
      rsp_due.delete();
    end else begin
      if (req.valid && req.ready) begin
        rsp_due.push_back(stack_apply(req.opcode, req.stack_sel, req.push_value));
      end
      if (rsp.valid && rsp.ready) begin
        if (rsp_due.size() == 0) begin
          $display("%0t: response with no request waiting, expected none, actual status %h",
                   $time, rsp.status);
          fails++;
        end else begin
          want = rsp_due.pop_front();
          check_field("top_value", want.top_value, rsp.top_value);
          check_field("status", WORD_W'(want.status), WORD_W'(rsp.status));
          check_field("lower_empty", WORD_W'(want.lower_empty), WORD_W'(rsp.lower_empty));
          check_field("upper_empty", WORD_W'(want.upper_empty), WORD_W'(rsp.upper_empty));
          check_field("all_full", WORD_W'(want.all_full), WORD_W'(rsp.all_full));
        end
      end
    end
    fail_count  <= fails;
    outstanding <= rsp_due.size();
  end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import dssm_pkg::*;

  localparam int DEPTH       = DEPTH_DEFAULT;
  localparam int ITEMS       = 1650;
  localparam int QUIET_ITEMS = 150;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  logic clk = 1'b0;
  logic rst_n;
  logic quiet = 1'b0;
  logic rsp_ready = 1'b0;
  int   stall_left = 0;
  int   cycles = 0;
  int   sent = 0;
  int   fail_count;
  int   outstanding;

  dssm_req_if in_req ();
  dssm_rsp_if out_rsp ();

  assign out_rsp.ready = rsp_ready;

  dual_stack_shared_memory #(.DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  dssm_checker #(.DEPTH(DEPTH)) stack_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (in_req),
    .rsp        (out_rsp),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      rsp_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      rsp_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 16);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  task automatic send_req(input logic [OP_W-1:0] op, input logic sel,
                          input logic [WORD_W-1:0] val);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_req.valid      <= 1'b1;
    in_req.opcode     <= op;
    in_req.stack_sel  <= sel;
    in_req.push_value <= val;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    sent++;
  endtask

  task automatic wait_drained();
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int              seg_len;
    int              mode;
    int              upper_pct;
    int              push_pct;
    int              pop_pct;
    int              roll;
    logic [OP_W-1:0] op;
    logic            paused;

    paused            = 1'b0;
    rst_n             <= 1'b0;
    in_req.valid      <= 1'b0;
    in_req.opcode     <= OP_PUSH;
    in_req.stack_sel  <= 1'b0;
    in_req.push_value <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty stacks first, then extreme words on both sides and back to empty.
    send_req(OP_READ, 1'b0, '0);
    send_req(OP_READ, 1'b1, '0);
    send_req(OP_POP, 1'b0, '0);
    send_req(OP_POP, 1'b1, '0);
    send_req(OP_NONE, 1'b0, '1);
    send_req(OP_NONE, 1'b1, '1);
    send_req(OP_PUSH, 1'b0, 32'h7FFF_FFFF);
    send_req(OP_PUSH, 1'b1, 32'h8000_0000);
    send_req(OP_READ, 1'b0, '0);
    send_req(OP_READ, 1'b1, '0);
    send_req(OP_PUSH, 1'b0, '0);
    send_req(OP_PUSH, 1'b1, '1);
    send_req(OP_READ, 1'b0, '1);
    send_req(OP_READ, 1'b1, '1);
    send_req(OP_NONE, 1'b0, '0);
    send_req(OP_POP, 1'b0, '0);
    send_req(OP_READ, 1'b0, '0);
    send_req(OP_POP, 1'b0, '0);
    send_req(OP_POP, 1'b0, '0);
    send_req(OP_POP, 1'b1, '0);
    send_req(OP_READ, 1'b1, '0);
    send_req(OP_POP, 1'b1, '0);
    send_req(OP_READ, 1'b1, '0);

    // Runs of pushes fill the memory and runs of pops empty it again, so the
    // full and empty edges are crossed many times from both sides.
    while (sent < ITEMS) begin
      if (!paused && sent >= ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      seg_len = $urandom_range(4, 48);
      mode    = $urandom_range(MODE_FILL, MODE_MIXED);
      case ($urandom_range(0, 3))
        0: upper_pct = 0;
        1: upper_pct = 100;
        2: upper_pct = 50;
        default: upper_pct = $urandom_range(0, 100);
      endcase
      case (mode)
        MODE_FILL: begin
          push_pct = 78;
          pop_pct  = 12;
        end
        MODE_DRAIN: begin
          push_pct = 18;
          pop_pct  = 62;
        end
        default: begin
          push_pct = 45;
          pop_pct  = 30;
        end
      endcase
      for (int i = 0; i < seg_len && sent < ITEMS; i++) begin
        quiet = (sent >= ITEMS - QUIET_ITEMS);
        roll  = $urandom_range(0, 99);
        if (roll < 3) begin
          op = OP_NONE;
        end else if (roll < push_pct) begin
          op = OP_PUSH;
        end else if (roll < push_pct + pop_pct) begin
          op = OP_POP;
        end else begin
          op = OP_READ;
        end
        send_req(op, $urandom_range(0, 99) < upper_pct, pick_word());
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
sv/dssm_pkg.sv
sv/dssm_req_if.sv
sv/dssm_rsp_if.sv
sv/dssm_ctrl.sv
sv/dssm_dp.sv
sv/dual_stack_shared_memory.sv
sim/dssm_checker.sv
sim/tb.sv
